// ----- rtl/sbs_pkg.sv -----
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants for the sorted store with binary search.
// ----------------------------------------------------------------------------
package sbs_pkg;

    localparam int DEFAULT_STORE_DEPTH = 256;
    localparam int VALUE_W             = 32;
    localparam int POSITION_W          = 8;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    typedef struct packed {
        logic [1:0]                 command;
        logic signed [VALUE_W-1:0]  value;
    } cmd_item_t;

    typedef struct packed {
        logic                   found;
        logic [POSITION_W-1:0]  position;
    } res_item_t;

endpackage

// ----- rtl/sbs_ram.sv -----
// ----------------------------------------------------------------------------
// sbs_ram
// Single-port-write, single-port-read synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module sbs_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/sbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbs_ctrl
// Command sequencer: clear, append, selection sort over the memory, binary search.
// ----------------------------------------------------------------------------
module sbs_ctrl #(
    parameter int STORE_DEPTH = 256,
    parameter int AW          = $clog2(STORE_DEPTH),
    parameter int CW          = $clog2(STORE_DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  sbs_pkg::cmd_item_t          cmd,
    output logic                        res_valid,
    input  logic                        res_ready,
    output sbs_pkg::res_item_t          res,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [sbs_pkg::VALUE_W-1:0] mem_wdata,
    output logic [AW-1:0]               mem_raddr,
    input  logic [sbs_pkg::VALUE_W-1:0] mem_rdata
);

    import sbs_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_SORT_HEAD = 8'b0000_0010,
        ST_SORT_SCAN = 8'b0000_0100,
        ST_SWAP_HEAD = 8'b0000_1000,
        ST_SWAP_PICK = 8'b0001_0000,
        ST_PROBE     = 8'b0010_0000,
        ST_COMPARE   = 8'b0100_0000,
        ST_DONE      = 8'b1000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic                       sorted_reg, sorted_next;
    logic                       res_valid_reg, res_valid_next;

    logic [CW-1:0]              head_reg, head_next;
    logic [CW-1:0]              scan_reg, scan_next;
    logic [AW-1:0]              rd_addr_reg, rd_addr_next;
    logic                       first_reg, first_next;
    logic signed [VALUE_W-1:0]  min_reg, min_next;
    logic signed [VALUE_W-1:0]  head_val_reg, head_val_next;
    logic [AW-1:0]              pick_reg, pick_next;
    logic signed [VALUE_W-1:0]  key_reg, key_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic [CW-1:0]              mid_reg, mid_next;
    logic                       found_reg, found_next;
    logic [POSITION_W-1:0]      pos_reg, pos_next;
    res_item_t                  res_reg, res_next;

    logic signed [VALUE_W-1:0]  rdata_s;
    logic [CW:0]                mid_sum;
    logic [CW-1:0]              mid_calc;
    logic                       cmd_take;

    assign rdata_s   = $signed(mem_rdata);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc  = mid_sum[CW:1];
    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_take  = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sorted_next    = sorted_reg;
        res_valid_next = res_valid_reg;
        head_next      = head_reg;
        scan_next      = scan_reg;
        rd_addr_next   = rd_addr_reg;
        first_next     = first_reg;
        min_next       = min_reg;
        head_val_next  = head_val_reg;
        pick_next      = pick_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = head_reg[AW-1:0];
        mem_wdata      = min_reg;
        mem_raddr      = head_reg[AW-1:0];

        // The result is released once the consumer takes it.
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    unique case (cmd.command)
                        CMD_CLEAR:
                        begin
                            count_next  = '0;
                            sorted_next = 1'b1;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg < CW'(STORE_DEPTH))
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = count_reg[AW-1:0];
                                mem_wdata   = cmd.value;
                                count_next  = count_reg + 1'b1;
                                sorted_next = 1'b0;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            key_next = cmd.value;
                            if (!sorted_reg && (count_reg > CW'(1)))
                            begin
                                head_next  = '0;
                                state_next = ST_SORT_HEAD;
                            end
                            else
                            begin
                                sorted_next = 1'b1;
                                lo_next     = '0;
                                hi_next     = count_reg;
                                state_next  = ST_PROBE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SORT_HEAD:
            begin
                mem_raddr  = head_reg[AW-1:0];
                rd_addr_next = head_reg[AW-1:0];
                scan_next  = head_reg + 1'b1;
                first_next = 1'b1;
                state_next = ST_SORT_SCAN;
            end
            ST_SORT_SCAN:
            begin
                // Read data here belongs to the address issued in the previous cycle.
                if (first_reg)
                begin
                    head_val_next = rdata_s;
                    min_next      = rdata_s;
                    pick_next     = head_reg[AW-1:0];
                end
                else if (rdata_s < min_reg)
                begin
                    min_next  = rdata_s;
                    pick_next = rd_addr_reg;
                end
                first_next = 1'b0;
                if (scan_reg < count_reg)
                begin
                    mem_raddr    = scan_reg[AW-1:0];
                    rd_addr_next = scan_reg[AW-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_SWAP_HEAD;
                end
            end
            ST_SWAP_HEAD:
            begin
                mem_we     = 1'b1;
                mem_waddr  = head_reg[AW-1:0];
                mem_wdata  = min_reg;
                state_next = ST_SWAP_PICK;
            end
            ST_SWAP_PICK:
            begin
                mem_we    = 1'b1;
                mem_waddr = pick_reg;
                mem_wdata = head_val_reg;
                head_next = head_reg + 1'b1;
                if (({1'b0, head_reg} + (CW+1)'(2)) < {1'b0, count_reg})
                begin
                    state_next = ST_SORT_HEAD;
                end
                else
                begin
                    sorted_next = 1'b1;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    state_next  = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    mem_raddr  = mid_calc[AW-1:0];
                    state_next = ST_COMPARE;
                end
                else
                begin
                    found_next = 1'b0;
                    pos_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_COMPARE:
            begin
                if (rdata_s == key_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = POSITION_W'(mid_reg);
                    state_next = ST_DONE;
                end
                else if (rdata_s > key_reg)
                begin
                    hi_next    = mid_reg;
                    state_next = ST_PROBE;
                end
                else
                begin
                    lo_next    = mid_reg + 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.found    = found_reg;
                    res_next.position = pos_reg;
                    res_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sorted_reg    <= 1'b1;
            res_valid_reg <= 1'b0;
            head_reg      <= '0;
            scan_reg      <= '0;
            first_reg     <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sorted_reg    <= sorted_next;
            res_valid_reg <= res_valid_next;
            head_reg      <= head_next;
            scan_reg      <= scan_next;
            first_reg     <= first_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        min_reg      <= min_next;
        head_val_reg <= head_val_next;
        pick_reg     <= pick_next;
        key_reg      <= key_next;
        mid_reg      <= mid_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        res_reg      <= res_next;
    end

endmodule

// ----- rtl/sort_then_binary_search.sv -----
// ----------------------------------------------------------------------------
// sort_then_binary_search
// Value store with on-demand selection sort and binary search.
// ----------------------------------------------------------------------------
// Commands arrive one transfer at a time: clear empties the store, append
// writes a signed value at the end (ignored when the store is full), and
// search returns one result transfer with a found flag and the index of the
// match in ascending order. Clear and append are handled without leaving the
// idle state. A search alternates a probe state and a compare state, then
// passes to a done state that loads the result. If values were appended
// since the last sort and the store holds more than one value, the search
// first selection-sorts the store in place, using the single memory read
// port once per scanned element. No new command is taken while a search or
// sort runs, and the result is held in an output register until the consumer
// takes it.
module sort_then_binary_search #(
    parameter int STORE_DEPTH = sbs_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  sbs_pkg::cmd_item_t cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output sbs_pkg::res_item_t res
);

    import sbs_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    sbs_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sbs_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (VALUE_W),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
